>>> rtl/assert_macros.svh
// ----------------------------------------------------------------------------
// assert_macros.svh
// Assertion helpers shared by the filter RTL. Each macro expects clk and
// arst_n in scope and is disabled while reset is asserted.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Property that must hold at every clock edge out of reset
`define SBBF_ASSERT(lbl, prop, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (prop)) \
		else $error(msg);

// Antecedent this cycle, consequent on the following edge
`define SBBF_ASSERT_NEXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

>>> rtl/sbbf_pkg.sv
// ----------------------------------------------------------------------------
// sbbf_pkg
// Constants, salts, types and the probe-mask helper of the split-block
// Bloom filter.
// ----------------------------------------------------------------------------
`default_nettype none

package sbbf_pkg;

	// Geometry
	localparam int MAX_BLOCKS      = 256;
	localparam int WORDS_PER_BLOCK = 8;
	localparam int WORD_W          = 32;
	localparam int ROW_W           = WORDS_PER_BLOCK * WORD_W;
	localparam int ROW_AW          = (MAX_BLOCKS > 1) ? $clog2(MAX_BLOCKS) : 1;

	// Field widths
	localparam int CNT_W     = 9;
	localparam int KEY_W     = 64;
	localparam int HALF_W    = 32;
	localparam int POS_W     = 5;
	localparam int POS_SHIFT = 27;

	// Opcodes
	localparam logic OP_INSERT = 1'b0;
	localparam logic OP_QUERY  = 1'b1;

	// Result queue
	localparam int RSP_DEPTH = 8;
	localparam int RSP_AW    = $clog2(RSP_DEPTH);
	localparam int RSP_CW    = $clog2(RSP_DEPTH + 1);

	// Published salts, one per word of a block
	localparam logic [WORD_W-1:0] SALT [WORDS_PER_BLOCK] = '{
		32'h47b6137b, 32'h44974d91, 32'h8824ad5b, 32'ha2b7289d,
		32'h705495c7, 32'h2df1424b, 32'h9efc4947, 32'h5c6bfb31
	};

	typedef logic [ROW_W-1:0]                         row_t;
	typedef logic [ROW_AW-1:0]                        row_addr_t;
	typedef logic [WORDS_PER_BLOCK-1:0][POS_W-1:0]    pos_vec_t;

	// Write request into the block store
	typedef struct packed {
		logic      we;
		row_addr_t waddr;
		row_t      wdata;
	} store_wr_t;

	// One bit per word, at the word's probe position
	function automatic row_t probe_row(input pos_vec_t pos);
		row_t r;
		r = '0;
		for (int i = 0; i < WORDS_PER_BLOCK; i++) begin
			r[i*WORD_W +: WORD_W] = WORD_W'(1) << pos[i];
		end
		return r;
	endfunction

endpackage

`default_nettype wire

>>> rtl/sbbf_req_if.sv
// ----------------------------------------------------------------------------
// sbbf_req_if
// Request channel: opcode and 64-bit key hash with valid/ready.
// ----------------------------------------------------------------------------
`default_nettype none

interface sbbf_req_if;
	logic                      valid;
	logic                      ready;
	logic                      opcode;
	logic [sbbf_pkg::KEY_W-1:0] key_hash;

	modport source (output valid, output opcode, output key_hash, input ready);
	modport sink   (input valid, input opcode, input key_hash, output ready);
endinterface

`default_nettype wire

>>> rtl/sbbf_rsp_if.sv
// ----------------------------------------------------------------------------
// sbbf_rsp_if
// Response channel: membership answer with valid/ready.
// ----------------------------------------------------------------------------
`default_nettype none

interface sbbf_rsp_if;
	logic valid;
	logic ready;
	logic may_contain;

	modport source (output valid, output may_contain, input ready);
	modport sink   (input valid, input may_contain, output ready);
endinterface

`default_nettype wire

>>> rtl/sbbf_store.sv
// ----------------------------------------------------------------------------
// sbbf_store
// Block store: one 256-bit row per block, synchronous (registered) read,
// per-row valid bits for reset clearing, and write-to-read
// forwarding for a row written on the same edge it is read.
// ----------------------------------------------------------------------------
`default_nettype none

module sbbf_store (
	input  wire                  clk,
	input  wire                  arst_n,
	input  sbbf_pkg::row_addr_t  raddr,
	input  sbbf_pkg::store_wr_t  wr,
	output sbbf_pkg::row_t       rdata
);

	sbbf_pkg::row_t                      mem [sbbf_pkg::MAX_BLOCKS];
	logic [sbbf_pkg::MAX_BLOCKS-1:0]     vld_q;
	sbbf_pkg::row_t                      rd_q;
	logic                                rd_vld_q;
	logic                                fwd_hit_q;
	sbbf_pkg::row_t                      fwd_data_q;

	// Memory array: read every cycle, write on request
	always_ff @(posedge clk) begin
		rd_q <= mem[raddr];
		if (wr.we) begin
			mem[wr.waddr] <= wr.wdata;
		end
	end

	// Row valid bits, cleared at reset; unwritten rows read as zero
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q    <= '0;
			rd_vld_q <= 1'b0;
		end else begin
			rd_vld_q <= vld_q[raddr];
			if (wr.we) begin
				vld_q[wr.waddr] <= 1'b1;
			end
		end
	end

	// Same-edge write and read of one row: the read saw old data
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			fwd_hit_q <= 1'b0;
		end else begin
			fwd_hit_q <= wr.we && (wr.waddr == raddr);
		end
	end

	always_ff @(posedge clk) begin
		fwd_data_q <= wr.wdata;
	end

	assign rdata = fwd_hit_q ? fwd_data_q : (rd_vld_q ? rd_q : '0);

endmodule

`default_nettype wire

>>> rtl/split_block_bloom_filter_core.sv
// ----------------------------------------------------------------------------
// split_block_bloom_filter_core
// Split-block Bloom filter: insert or query a 64-bit key hash against a
// store of 256-bit blocks, one block read per item and a write-back for inserts.
//
//   Channel  Dir  Handshake      Payload
//   req      in   valid/ready    opcode, key_hash[63:0]
//   rsp      out  valid/ready    may_contain (queries only)
//   cfg      in   cfg_we         cfg_wdata[8:0] = block_count
//
// One item per cycle sustained while the response queue has room; set by the single block-store read port,
// with forwarding covering back-to-back items on the same block.
// From accept to response valid an item passes the stage 1, 2 and 3 registers
// (hash, read, modify), and the answer then enters the response queue.
// Reset clears row valid bits at once: no clearing pass, ready right away.
// req.ready drops when queued plus in-flight items reach 8 (queue depth).
// ----------------------------------------------------------------------------
`default_nettype none

module split_block_bloom_filter_core (
	input  wire                          clk,
	input  wire                          arst_n,
	input  wire                          cfg_we,
	input  wire [sbbf_pkg::CNT_W-1:0]    cfg_wdata,
	sbbf_req_if.sink                     req,
	sbbf_rsp_if.source                   rsp
);

	// Configuration
	logic [sbbf_pkg::CNT_W-1:0] block_count_q;

	// Stage 1: accepted beat
	logic                          v_s1;
	logic                          op_s1;
	logic [sbbf_pkg::KEY_W-1:0]    key_s1;

	// Stage 2: block index and probe positions
	logic                          v_s2;
	logic                          op_s2;
	logic                          empty_s2;
	sbbf_pkg::row_addr_t           row_s2;
	sbbf_pkg::pos_vec_t            pos_s2;

	// Stage 3: row data back from store
	logic                          v_s3;
	logic                          op_s3;
	logic                          empty_s3;
	sbbf_pkg::row_addr_t           row_s3;
	sbbf_pkg::row_t                mask_s3;

	// Hash math
	logic [sbbf_pkg::CNT_W-1:0]            blocks_c;
	logic [sbbf_pkg::HALF_W+sbbf_pkg::CNT_W-1:0] blk_prod_c;
	sbbf_pkg::pos_vec_t                    pos_c;

	// Store access
	sbbf_pkg::row_t      rd_row;
	sbbf_pkg::store_wr_t wr;
	logic                hit_c;

	// Response queue
	logic [sbbf_pkg::RSP_DEPTH-1:0] rq_q;
	logic [sbbf_pkg::RSP_AW-1:0]    rq_wp_q;
	logic [sbbf_pkg::RSP_AW-1:0]    rq_rp_q;
	logic [sbbf_pkg::RSP_CW-1:0]    rq_cnt_q;
	logic                           push;
	logic                           pop;
	logic [1:0]                     inflight;
	logic [sbbf_pkg::RSP_CW:0]      credit_used;
	logic                           acc;

	// Block count register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			block_count_q <= '0;
		end else if (cfg_we) begin
			block_count_q <= cfg_wdata;
		end
	end

	// Accept when queue plus in-flight work leaves room for the result
	assign inflight    = 2'(v_s1) + 2'(v_s2) + 2'(v_s3);
	assign credit_used = (sbbf_pkg::RSP_CW+1)'(rq_cnt_q) + (sbbf_pkg::RSP_CW+1)'(inflight);
	assign req.ready   = credit_used < (sbbf_pkg::RSP_CW+1)'(sbbf_pkg::RSP_DEPTH);
	assign acc         = req.valid && req.ready;

	// Pipeline valids
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
		end else begin
			v_s1 <= acc;
			v_s2 <= v_s1;
			v_s3 <= v_s2;
		end
	end

	// Stage 1 capture
	always_ff @(posedge clk) begin
		op_s1  <= req.opcode;
		key_s1 <= req.key_hash;
	end

	// Saturate block count at capacity
	always_comb begin
		if (32'(block_count_q) > sbbf_pkg::MAX_BLOCKS) begin
			blocks_c = sbbf_pkg::CNT_W'(sbbf_pkg::MAX_BLOCKS);
		end else begin
			blocks_c = block_count_q;
		end
	end

	// Block index: upper half scaled by block count
	assign blk_prod_c =
		(sbbf_pkg::HALF_W+sbbf_pkg::CNT_W)'(key_s1[sbbf_pkg::KEY_W-1 -: sbbf_pkg::HALF_W]) *
		(sbbf_pkg::HALF_W+sbbf_pkg::CNT_W)'(blocks_c);

	// Probe positions: top bits of low half times each salt, mod 2^32
	always_comb begin
		logic [sbbf_pkg::WORD_W-1:0] sp;
		sp = '0;
		for (int i = 0; i < sbbf_pkg::WORDS_PER_BLOCK; i++) begin
			sp       = key_s1[sbbf_pkg::HALF_W-1:0] * sbbf_pkg::SALT[i];
			pos_c[i] = sp[sbbf_pkg::POS_SHIFT +: sbbf_pkg::POS_W];
		end
	end

	// Stage 2 capture
	always_ff @(posedge clk) begin
		op_s2    <= op_s1;
		empty_s2 <= (blocks_c == '0);
		row_s2   <= blk_prod_c[sbbf_pkg::HALF_W +: sbbf_pkg::ROW_AW];
		pos_s2   <= pos_c;
	end

	// Stage 3 capture; store read issued from row_s2 this cycle
	always_ff @(posedge clk) begin
		op_s3    <= op_s2;
		empty_s3 <= empty_s2;
		row_s3   <= row_s2;
		mask_s3  <= sbbf_pkg::probe_row(pos_s2);
	end

	sbbf_store u_store (
		.clk    (clk),
		.arst_n (arst_n),
		.raddr  (row_s2),
		.wr     (wr),
		.rdata  (rd_row)
	);

	// Modify and write back
	assign hit_c    = ((rd_row & mask_s3) == mask_s3) && !empty_s3;
	assign wr.we    = v_s3 && (op_s3 == sbbf_pkg::OP_INSERT) && !empty_s3;
	assign wr.waddr = row_s3;
	assign wr.wdata = rd_row | mask_s3;

	// Response queue
	assign push            = v_s3 && (op_s3 == sbbf_pkg::OP_QUERY);
	assign pop             = rsp.valid && rsp.ready;
	assign rsp.valid       = (rq_cnt_q != '0);
	assign rsp.may_contain = rq_q[rq_rp_q];

	always_ff @(posedge clk) begin
		if (push) begin
			rq_q[rq_wp_q] <= hit_c;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rq_wp_q  <= '0;
			rq_rp_q  <= '0;
			rq_cnt_q <= '0;
		end else begin
			if (push) begin
				rq_wp_q <= rq_wp_q + 1'b1;
			end
			if (pop) begin
				rq_rp_q <= rq_rp_q + 1'b1;
			end
			case ({push, pop})
				2'b10:   rq_cnt_q <= rq_cnt_q + 1'b1;
				2'b01:   rq_cnt_q <= rq_cnt_q - 1'b1;
				default: rq_cnt_q <= rq_cnt_q;
			endcase
		end
	end

	// Assertions
`include "assert_macros.svh"

	`SBBF_ASSERT(a_credit_bound,
		credit_used <= (sbbf_pkg::RSP_CW+1)'(sbbf_pkg::RSP_DEPTH),
		"queued plus in-flight items exceed response queue depth")

	`SBBF_ASSERT(a_no_overflow,
		!push || pop || (rq_cnt_q < sbbf_pkg::RSP_CW'(sbbf_pkg::RSP_DEPTH)),
		"response pushed into a full queue")

	`SBBF_ASSERT_NEXT(a_no_stall, v_s1 || v_s2, v_s2 || v_s3,
		"pipeline lost an item between stages")

	`SBBF_ASSERT(a_fwd_insert_query,
		!(v_s3 && (op_s3 == sbbf_pkg::OP_QUERY) && $past(wr.we) &&
		  ($past(row_s3) == row_s3) && ($past(mask_s3) == mask_s3)) || hit_c,
		"query right after insert of the same hash missed")

endmodule

`default_nettype wire

>>> tb/split_block_bloom_filter_core_tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// split_block_bloom_filter_core_tb
// Drives insert and query beats into the split-block Bloom filter, keeps its
// own copy of the block store and the block count, and checks every
// membership answer against it. Covers the empty filter, extreme hashes and
// counts, count saturation, count changes over a filled store, random
// traffic with random gaps on both channels, and a long response hold-off.
// ----------------------------------------------------------------------------

module split_block_bloom_filter_core_tb;
	import sbbf_pkg::*;

	localparam int CYCLE_LIMIT   = 1000000;
	localparam int SETTLE_CYCLES = 12;
	localparam int MAX_REPORTS   = 10;
	localparam int STORE_WORDS   = MAX_BLOCKS * WORDS_PER_BLOCK;
	localparam int HOLD_CYCLES   = 300;

	typedef struct {
		logic             answer;
		logic [KEY_W-1:0] key;
	} answer_t;

	logic             clk = 1'b0;
	logic             arst_n;
	logic             cfg_we;
	logic [CNT_W-1:0] cfg_wdata;

	sbbf_req_if req_if ();
	sbbf_rsp_if rsp_if ();

	// Model of the filter
	bit   [WORD_W-1:0] filter_words [STORE_WORDS];
	logic [CNT_W-1:0]  model_block_count;
	answer_t           pending_answers [$];
	logic [KEY_W-1:0]  inserted_keys [$];

	int mismatch_count   = 0;
	int cycle_count      = 0;
	int rsp_hold_request = 0;
	bit req_gaps_on;
	bit rsp_stalls_on;

	split_block_bloom_filter_core i_dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_wdata (cfg_wdata),
		.req       (req_if),
		.rsp       (rsp_if)
	);

	always begin
		#1 clk = 1'b1;
		#1 clk = 1'b0;
	end

	// Parquet salts, one per word of a block
	function automatic logic [WORD_W-1:0] word_salt(input int w);
		case (w)
			0: return 32'h47b6137b;
			1: return 32'h44974d91;
			2: return 32'h8824ad5b;
			3: return 32'ha2b7289d;
			4: return 32'h705495c7;
			5: return 32'h2df1424b;
			6: return 32'h9efc4947;
			default: return 32'h5c6bfb31;
		endcase
	endfunction

	// Update the store for an insert, or queue the answer of a query
	function automatic void apply_to_filter_model(input logic op, input logic [KEY_W-1:0] hash);
		logic [HALF_W-1:0] blocks;
		logic [WORD_W-1:0] prod;
		logic [WORD_W-1:0] mask;
		logic [63:0]       row;
		int                addr;
		logic              all_set;
		answer_t           a;
		blocks = HALF_W'(model_block_count);
		if (blocks > MAX_BLOCKS)
			blocks = MAX_BLOCKS;
		all_set = (blocks != 0);
		if (blocks != 0) begin
			row = (64'(hash[63:32]) * 64'(blocks)) >> 32;
			for (int w = 0; w < WORDS_PER_BLOCK; w++) begin
				prod = hash[31:0] * word_salt(w);
				mask = 32'd1 << prod[31:POS_SHIFT];
				addr = int'(row) * WORDS_PER_BLOCK + w;
				if (addr >= STORE_WORDS)
					addr = STORE_WORDS - 1;
				if (op == OP_INSERT)
					filter_words[addr] |= mask;
				else if ((filter_words[addr] & mask) == 0)
					all_set = 1'b0;
			end
		end
		if (op == OP_QUERY) begin
			a.answer = all_set;
			a.key    = hash;
			pending_answers.push_back(a);
		end
	endfunction

	// Mostly no gap, some short, a few long
	function automatic int draw_gap();
		int pick;
		pick = $urandom_range(0, 99);
		if (pick < 60)
			return 0;
		else if (pick < 92)
			return $urandom_range(1, 3);
		return $urandom_range(8, 40);
	endfunction

	function automatic logic [KEY_W-1:0] random_key();
		logic [HALF_W-1:0] hi;
		int                pick;
		pick = $urandom_range(0, 15);
		if (pick == 0)
			hi = '0;
		else if (pick == 1)
			hi = '1;
		else
			hi = $urandom;
		return {hi, HALF_W'($urandom)};
	endfunction

	// Half the queries revisit inserted keys, some with one bit flipped
	function automatic logic [KEY_W-1:0] query_key();
		logic [KEY_W-1:0] k;
		if (inserted_keys.size() == 0 || $urandom_range(0, 1) == 0)
			return random_key();
		k = inserted_keys[$urandom_range(0, inserted_keys.size() - 1)];
		if ($urandom_range(0, 7) == 0)
			k[$urandom_range(0, KEY_W - 1)] ^= 1'b1;
		return k;
	endfunction

	// Offer one beat and wait for it to be taken
	task automatic issue_request(input logic op, input logic [KEY_W-1:0] hash);
		int gap;
		gap = req_gaps_on ? draw_gap() : 0;
		@(negedge clk);
		if (gap > 0) begin
			req_if.valid = 1'b0;
			repeat (gap) @(negedge clk);
		end
		req_if.valid    = 1'b1;
		req_if.opcode   = op;
		req_if.key_hash = hash;
		do @(posedge clk); while (req_if.ready !== 1'b1);
		apply_to_filter_model(op, hash);
		if (op == OP_INSERT)
			inserted_keys.push_back(hash);
	endtask

	// Stop offering, let all answers come back and the pipeline settle
	task automatic wait_for_idle();
		@(negedge clk);
		req_if.valid = 1'b0;
		while (pending_answers.size() != 0)
			@(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	task automatic write_block_count(input logic [CNT_W-1:0] value);
		wait_for_idle();
		@(negedge clk);
		cfg_we    = 1'b1;
		cfg_wdata = value;
		@(posedge clk);
		model_block_count = value;
		@(negedge clk);
		cfg_we = 1'b0;
	endtask

	// Count zero after reset: inserts ignored, queries answer 0
	task automatic test_empty_filter();
		issue_request(OP_INSERT, 64'h0123_4567_89ab_cdef);
		issue_request(OP_QUERY,  64'h0123_4567_89ab_cdef);
		issue_request(OP_QUERY,  64'h0);
		issue_request(OP_QUERY,  '1);
	endtask

	// Extreme hashes and counts, saturation, count changes over set bits
	task automatic test_extremes();
		write_block_count(CNT_W'(1));
		issue_request(OP_INSERT, 64'h0);
		issue_request(OP_QUERY,  64'h0);
		issue_request(OP_INSERT, '1);
		issue_request(OP_QUERY,  '1);
		issue_request(OP_QUERY,  64'h0000_0000_ffff_ffff);
		write_block_count(CNT_W'(MAX_BLOCKS));
		issue_request(OP_INSERT, 64'hffff_ffff_0000_0000);
		issue_request(OP_QUERY,  64'hffff_ffff_0000_0000);
		issue_request(OP_QUERY,  64'h0000_0000_ffff_ffff);
		// above capacity: same mapping as the full count
		write_block_count('1);
		issue_request(OP_QUERY,  64'hffff_ffff_0000_0000);
		issue_request(OP_INSERT, 64'h8000_0000_1234_5678);
		issue_request(OP_QUERY,  64'h8000_0000_1234_5678);
		// new count keeps the store
		write_block_count(CNT_W'(2));
		issue_request(OP_QUERY,  64'h0);
		issue_request(OP_QUERY,  '1);
		write_block_count('0);
		issue_request(OP_QUERY,  '1);
		issue_request(OP_INSERT, 64'hdead_beef_0bad_f00d);
		write_block_count(CNT_W'(1));
		issue_request(OP_QUERY,  64'hdead_beef_0bad_f00d);
	endtask

	// Phases of mixed traffic, each under its own count
	task automatic test_random_traffic();
		int   phase_counts [16];
		int   items;
		logic op;
		phase_counts = '{1, 2, 3, 5, 8, 16, 0, 40, 128, 255, 256, 257, 511, 0, 0, 0};
		for (int p = 13; p < 16; p++)
			phase_counts[p] = $urandom_range(1, 511);
		for (int p = 0; p < 16; p++) begin
			write_block_count(CNT_W'(phase_counts[p]));
			req_gaps_on   = (p != 0) && ($urandom_range(0, 3) != 0);
			rsp_stalls_on = (p != 0) && ($urandom_range(0, 3) != 0);
			items = (phase_counts[p] == 0) ? 30 : 105;
			for (int n = 0; n < items; n++) begin
				op = ($urandom_range(0, 99) < 45) ? OP_INSERT : OP_QUERY;
				issue_request(op, (op == OP_INSERT) ? random_key() : query_key());
			end
		end
	endtask

	// Long response hold-off while queries keep coming: input must stall
	task automatic test_backpressure();
		write_block_count(CNT_W'(3));
		req_gaps_on      = 1'b0;
		rsp_stalls_on    = 1'b0;
		rsp_hold_request = HOLD_CYCLES;
		for (int n = 0; n < 48; n++)
			issue_request(OP_QUERY, query_key());
		wait_for_idle();
	endtask

	// Response ready: random stalls, plus the requested hold-off
	initial begin : drive_rsp_ready
		int stall;
		rsp_if.ready = 1'b0;
		wait (arst_n === 1'b1);
		forever begin
			@(negedge clk);
			if (rsp_hold_request > 0) begin
				stall            = rsp_hold_request;
				rsp_hold_request = 0;
				rsp_if.ready     = 1'b0;
				repeat (stall) @(posedge clk);
			end else if (rsp_stalls_on && $urandom_range(0, 99) < 25) begin
				stall        = draw_gap() + 1;
				rsp_if.ready = 1'b0;
				repeat (stall - 1) @(negedge clk);
			end else begin
				rsp_if.ready = 1'b1;
			end
		end
	end

	// Compare each answer beat with the oldest expected one
	always @(posedge clk) begin : check_answers
		answer_t a;
		if (arst_n === 1'b1 && rsp_if.valid === 1'b1 && rsp_if.ready === 1'b1) begin
			if (pending_answers.size() == 0) begin
				mismatch_count++;
				if (mismatch_count <= MAX_REPORTS)
					$display("%0t: unexpected answer beat, may_contain=%b", $realtime,
						rsp_if.may_contain);
			end else begin
				a = pending_answers.pop_front();
				if (rsp_if.may_contain !== a.answer) begin
					mismatch_count++;
					if (mismatch_count <= MAX_REPORTS)
						$display("%0t: key %h: may_contain expected %b, got %b", $realtime,
							a.key, a.answer, rsp_if.may_contain);
				end
			end
		end
	end

	// Watchdog
	always @(posedge clk) begin
		cycle_count++;
		if (cycle_count >= CYCLE_LIMIT) begin
			$display("Test completed with failures");
			$finish;
		end
	end

	initial begin : run_tests
		arst_n            = 1'b0;
		cfg_we            = 1'b0;
		cfg_wdata         = '0;
		req_if.valid      = 1'b0;
		req_if.opcode     = OP_INSERT;
		req_if.key_hash   = '0;
		model_block_count = '0;
		req_gaps_on       = 1'b0;
		rsp_stalls_on     = 1'b0;
		repeat (4) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		test_empty_filter();
		test_extremes();
		test_random_traffic();
		test_backpressure();
		wait_for_idle();

		if (mismatch_count == 0 && pending_answers.size() == 0)
			$display("Test completed successfully");
		else
			$display("Test completed with failures");
		$finish;
	end

endmodule

>>> files.f
+incdir+rtl
rtl/sbbf_pkg.sv
rtl/sbbf_req_if.sv
rtl/sbbf_rsp_if.sv
rtl/sbbf_store.sv
rtl/split_block_bloom_filter_core.sv
tb/split_block_bloom_filter_core_tb.sv
